### design/qjts_pkg.sv
// Shared types and constants of the two-level quantum jump step core.
// No dependencies; used by every module of the block.
package qjts_pkg;

    localparam int AMP_W     = 32;
    localparam int AMP_FRAC  = AMP_W - 2;
    localparam int RND_W     = 16;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int POP_W     = 17;
    localparam int COEF_FRAC = 20;
    localparam int OP_W      = AMP_W + 2;
    localparam int ACC_W     = 2 * OP_W;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int NUM_W     = 62;
    localparam int CNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETUNING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd3;

    localparam logic OP_STEP    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [POP_W-1:0] POP_ONE = 17'h10000;

    typedef struct packed {
        logic             operation;
        logic [RND_W-1:0] random_fraction;
    } in_item_t;

    typedef struct packed {
        logic signed [AMP_W-1:0] ground_re;
        logic signed [AMP_W-1:0] ground_im;
        logic signed [AMP_W-1:0] excited_re;
        logic signed [AMP_W-1:0] excited_im;
        logic [POP_W-1:0]        ground_population;
        logic [POP_W-1:0]        excited_population;
        logic                    jumped;
    } out_item_t;

    typedef enum logic [2:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_NEG,
        ACC_ADD_HI
    } acc_mode_t;

    typedef struct packed {
        logic      mul_en;
        logic      acc_en;
        acc_mode_t mode;
    } mac_ctrl_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } sqdiv_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqdiv_stat_t;

endpackage

### design/qjts_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulation.
// Depends on qjts_pkg.
module qjts_mac
    import qjts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctrl_t               ctrl,
    input  logic signed [OP_W-1:0]  op_a,
    input  logic signed [OP_W-1:0]  op_b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        unique case (ctrl.mode)
            ACC_LOAD:   acc_next = prod_reg;
            ACC_ADD:    acc_next = acc_reg + prod_reg;
            ACC_SUB:    acc_next = acc_reg - prod_reg;
            ACC_NEG:    acc_next = -prod_reg;
            ACC_ADD_HI: acc_next = acc_reg + (prod_reg <<< 32);
            default:    acc_next = acc_reg;
        endcase
    end

    // The sequencer always loads the accumulator before it accumulates into it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.mul_en)
            begin
                prod_reg <= op_a * op_b;
            end
            if (ctrl.acc_en)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign acc = acc_reg;

endmodule

### design/qjts_sqdiv.sv
// Iterative shift-and-subtract unit: floor square root two bits a cycle,
// or long division one quotient bit a cycle. Depends on qjts_pkg.
module qjts_sqdiv
    import qjts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sqdiv_ctrl_t       ctrl,
    input  logic [RAD_W-1:0]  radicand,
    input  logic [NUM_W-1:0]  numer,
    input  logic [ROOT_W-1:0] divisor,
    output sqdiv_stat_t       stat,
    output logic [ROOT_W-1:0] result
);

    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0]  src_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              sqrt_reg;

    logic [ROOT_W+3:0] t_val;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              ge;

    always_comb
    begin
        if (sqrt_reg)
        begin
            t_val = {rem_reg, src_reg[RAD_W-1 -: 2]};
            trial = {2'b00, root_reg, 2'b01};
        end
        else
        begin
            t_val = {3'b000, rem_reg[ROOT_W-1:0], src_reg[RAD_W-1]};
            trial = {4'b0000, divisor};
        end
        diff = t_val - trial;
        ge   = (t_val >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            src_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= ctrl.is_sqrt;
                root_reg <= '0;
                if (ctrl.is_sqrt)
                begin
                    rem_reg <= '0;
                    src_reg <= radicand;
                    cnt_reg <= CNT_W'(ROOT_W - 1);
                end
                else
                begin
                    // The quotient fits in 31 bits, so the top of the numerator
                    // is already below the divisor.
                    rem_reg <= (ROOT_W+2)'(numer[NUM_W-1:ROOT_W-1]);
                    src_reg <= {numer[ROOT_W-2:0], (RAD_W-ROOT_W+1)'(0)};
                    cnt_reg <= CNT_W'(ROOT_W - 2);
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? diff[ROOT_W+1:0] : t_val[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                src_reg  <= sqrt_reg ? (src_reg << 2) : (src_reg << 1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = root_reg;

endmodule

### design/quantum_jump_two_level_step_core.sv
// Monte Carlo wavefunction step for a driven, damped two-level atom. The core is busy
// with one transaction at a time and drops in_ready until its result sits in the output
// register. A propagated step runs through the shared 34x34 multiply-accumulate unit
// (a multiply and an accumulate phase per product, and a store phase where a result is
// kept), the normalising shift (one or eight bits a cycle), the floor square root in
// the shift-subtract unit and the four divisions by the norm that follow it on the same
// unit.
// Depends on qjts_pkg, qjts_mac and qjts_sqdiv.
module quantum_jump_two_level_step_core
    import qjts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int M_W  = 61;
    localparam int A_W  = 27;
    localparam int CM_W = 28;
    localparam int CF_W = 29;

    localparam logic [1:0] K_GRE = 2'd0;
    localparam logic [1:0] K_GIM = 2'd1;
    localparam logic [1:0] K_ERE = 2'd2;
    localparam logic [1:0] K_EIM = 2'd3;

    localparam logic signed [AMP_W-1:0] AMP_ONE = AMP_W'(1) <<< AMP_FRAC;
    localparam logic signed [OP_W-1:0]  ONE_Q20 = OP_W'(1) <<< COEF_FRAC;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_SCALE,
        S_SQRT,
        S_DIVSET,
        S_DIV,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_MUL,
        PH_ACC,
        PH_ST
    } phase_t;

    typedef enum logic [4:0] {
        U_ER2, U_EI2, U_DTG, U_DPLO, U_DPHI,
        U_A, U_C,
        U_V0A, U_V0B, U_V1A, U_V1B,
        U_V2A, U_V2B, U_V2C, U_V3A, U_V3B, U_V3C,
        U_S0, U_S1, U_S2, U_S3,
        U_PG0, U_PG1, U_PE0, U_PE1
    } uop_t;

    state_t state_reg;
    phase_t ph_reg;
    uop_t   uop_reg;

    logic [CFG_W-1:0] drive_rate_reg;
    logic [CFG_W-1:0] detuning_reg;
    logic [CFG_W-1:0] decay_rate_reg;
    logic [CFG_W-1:0] time_step_reg;

    logic signed [AMP_W-1:0] amp_reg [4];
    logic [M_W-1:0]          m_reg [4];
    logic [3:0]              neg_reg;
    logic [1:0]              k_reg;

    logic [RND_W-1:0]       eps_reg;
    logic [23:0]            pop20_reg;
    logic [39:0]            dtg_reg;
    logic [A_W-1:0]         a_reg;
    logic signed [CF_W-1:0] c_reg;
    logic signed [CF_W-1:0] d_reg;
    logic [ROOT_W-1:0]      nrm_reg;
    logic                   jumped_reg;
    logic [POP_W-1:0]       pg_reg;
    logic [POP_W-1:0]       pe_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    mac_ctrl_t               mac_ctrl;
    logic signed [OP_W-1:0]  op_a;
    logic signed [OP_W-1:0]  op_b;
    logic signed [ACC_W-1:0] acc;
    acc_mode_t               mode;
    logic                    has_store;

    sqdiv_ctrl_t       sd_ctrl;
    sqdiv_stat_t       sd_stat;
    logic [NUM_W-1:0]  numer;
    logic [ROOT_W-1:0] sd_result;

    logic [39:0]            a_sum;
    logic [39:0]            b_sum;
    logic [39:0]            c_sum;
    logic [CFG_W-1:0]       dl_mag;
    logic signed [CF_W-1:0] c_next;
    logic signed [CF_W-1:0] d_next;
    logic [ACC_W-1:0]       acc_abs;
    logic [20:0]            pop_sum;
    logic [POP_W-1:0]       pop_sat;
    logic [RAD_W-1:0]       eps52;
    logic                   propagate;
    logic [M_W-1:0]         mor;
    logic [AMP_FRAC:0]      q_val;

    function automatic logic signed [OP_W-1:0] mag_op(input logic signed [AMP_W-1:0] x);
        logic [AMP_W:0] m;
        m = x[AMP_W-1] ? ({1'b0, ~x} + (AMP_W+1)'(1)) : {1'b0, x};
        return $signed({1'b0, m});
    endfunction

    function automatic logic signed [OP_W-1:0] sx_op(input logic signed [AMP_W-1:0] x);
        return {{(OP_W-AMP_W){x[AMP_W-1]}}, x};
    endfunction

    function automatic logic signed [OP_W-1:0] cf_op(input logic signed [CF_W-1:0] x);
        return {{(OP_W-CF_W){x[CF_W-1]}}, x};
    endfunction

    // Operand selection and accumulate mode of each micro-operation.
    always_comb
    begin
        op_a      = '0;
        op_b      = '0;
        mode      = ACC_LOAD;
        has_store = 1'b0;
        unique case (uop_reg)
            U_ER2:
            begin
                op_a = mag_op(amp_reg[K_ERE]);
                op_b = mag_op(amp_reg[K_ERE]);
            end
            U_EI2:
            begin
                op_a = mag_op(amp_reg[K_EIM]);
                op_b = mag_op(amp_reg[K_EIM]);
                mode = ACC_ADD;
                has_store = 1'b1;
            end
            U_DTG:
            begin
                op_a = $signed(OP_W'(time_step_reg));
                op_b = $signed(OP_W'(decay_rate_reg));
                has_store = 1'b1;
            end
            U_DPLO:
            begin
                op_a = $signed(OP_W'(dtg_reg[31:0]));
                op_b = $signed(OP_W'(pop20_reg));
            end
            U_DPHI:
            begin
                op_a = $signed(OP_W'(dtg_reg[39:32]));
                op_b = $signed(OP_W'(pop20_reg));
                mode = ACC_ADD_HI;
                has_store = 1'b1;
            end
            U_A:
            begin
                op_a = $signed(OP_W'(time_step_reg));
                op_b = $signed(OP_W'(drive_rate_reg));
                has_store = 1'b1;
            end
            U_C:
            begin
                op_a = $signed(OP_W'(time_step_reg));
                op_b = $signed(OP_W'(dl_mag));
                has_store = 1'b1;
            end
            U_V0A:
            begin
                op_a = sx_op(amp_reg[K_GRE]);
                op_b = ONE_Q20;
            end
            U_V0B:
            begin
                op_a = $signed(OP_W'(a_reg));
                op_b = sx_op(amp_reg[K_EIM]);
                mode = ACC_ADD;
                has_store = 1'b1;
            end
            U_V1A:
            begin
                op_a = sx_op(amp_reg[K_GIM]);
                op_b = ONE_Q20;
            end
            U_V1B:
            begin
                op_a = $signed(OP_W'(a_reg));
                op_b = sx_op(amp_reg[K_ERE]);
                mode = ACC_SUB;
                has_store = 1'b1;
            end
            U_V2A:
            begin
                op_a = $signed(OP_W'(a_reg));
                op_b = sx_op(amp_reg[K_GIM]);
            end
            U_V2B:
            begin
                op_a = cf_op(d_reg);
                op_b = sx_op(amp_reg[K_ERE]);
                mode = ACC_ADD;
            end
            U_V2C:
            begin
                op_a = cf_op(c_reg);
                op_b = sx_op(amp_reg[K_EIM]);
                mode = ACC_SUB;
                has_store = 1'b1;
            end
            U_V3A:
            begin
                op_a = $signed(OP_W'(a_reg));
                op_b = sx_op(amp_reg[K_GRE]);
                mode = ACC_NEG;
            end
            U_V3B:
            begin
                op_a = cf_op(d_reg);
                op_b = sx_op(amp_reg[K_EIM]);
                mode = ACC_ADD;
            end
            U_V3C:
            begin
                op_a = cf_op(c_reg);
                op_b = sx_op(amp_reg[K_ERE]);
                mode = ACC_ADD;
                has_store = 1'b1;
            end
            U_S0:
            begin
                op_a = $signed(OP_W'(m_reg[0][AMP_FRAC:0]));
                op_b = $signed(OP_W'(m_reg[0][AMP_FRAC:0]));
            end
            U_S1:
            begin
                op_a = $signed(OP_W'(m_reg[1][AMP_FRAC:0]));
                op_b = $signed(OP_W'(m_reg[1][AMP_FRAC:0]));
                mode = ACC_ADD;
            end
            U_S2:
            begin
                op_a = $signed(OP_W'(m_reg[2][AMP_FRAC:0]));
                op_b = $signed(OP_W'(m_reg[2][AMP_FRAC:0]));
                mode = ACC_ADD;
            end
            U_S3:
            begin
                op_a = $signed(OP_W'(m_reg[3][AMP_FRAC:0]));
                op_b = $signed(OP_W'(m_reg[3][AMP_FRAC:0]));
                mode = ACC_ADD;
                has_store = 1'b1;
            end
            U_PG0:
            begin
                op_a = mag_op(amp_reg[K_GRE]);
                op_b = mag_op(amp_reg[K_GRE]);
            end
            U_PG1:
            begin
                op_a = mag_op(amp_reg[K_GIM]);
                op_b = mag_op(amp_reg[K_GIM]);
                mode = ACC_ADD;
                has_store = 1'b1;
            end
            U_PE0:
            begin
                op_a = mag_op(amp_reg[K_ERE]);
                op_b = mag_op(amp_reg[K_ERE]);
            end
            U_PE1:
            begin
                op_a = mag_op(amp_reg[K_EIM]);
                op_b = mag_op(amp_reg[K_EIM]);
                mode = ACC_ADD;
                has_store = 1'b1;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Rounding of coefficients, magnitudes and populations taken from the accumulator.
    always_comb
    begin
        dl_mag   = detuning_reg[CFG_W-1] ? (~detuning_reg + CFG_W'(1)) : detuning_reg;
        a_sum    = acc[39:0] + 40'd4096;
        b_sum    = dtg_reg + 40'd4096;
        c_sum    = acc[39:0] + 40'd2048;
        c_next   = detuning_reg[CFG_W-1] ? -$signed({1'b0, c_sum[39:12]})
                                         : $signed({1'b0, c_sum[39:12]});
        d_next   = $signed(CF_W'(1) << COEF_FRAC) - $signed({2'b00, b_sum[39:13]});
        acc_abs  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        pop_sum  = {1'b0, acc[63:44]} + 21'(acc[43]);
        pop_sat  = (pop_sum > 21'(POP_ONE)) ? POP_ONE : pop_sum[POP_W-1:0];
        eps52    = RAD_W'(eps_reg) << (52 - RND_W);
        propagate = (eps52 >= acc[RAD_W-1:0]);
        mor      = m_reg[0] | m_reg[1] | m_reg[2] | m_reg[3];
        q_val    = sd_result[AMP_FRAC:0];
        numer    = NUM_W'({m_reg[k_reg][AMP_FRAC:0], AMP_FRAC'(0)})
                 + NUM_W'(nrm_reg[ROOT_W-1:1]);
    end

    assign mac_ctrl.mul_en = (state_reg == S_MAC) && (ph_reg == PH_MUL);
    assign mac_ctrl.acc_en = (state_reg == S_MAC) && (ph_reg == PH_ACC);
    assign mac_ctrl.mode   = mode;

    assign sd_ctrl.start   = ((state_reg == S_MAC) && (ph_reg == PH_ST) && (uop_reg == U_S3))
                           || (state_reg == S_DIVSET);
    assign sd_ctrl.is_sqrt = (state_reg == S_MAC);

    qjts_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    qjts_sqdiv u_sqdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sd_ctrl),
        .radicand (acc[RAD_W-1:0]),
        .numer    (numer),
        .divisor  (nrm_reg),
        .stat     (sd_stat),
        .result   (sd_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ph_reg         <= PH_MUL;
            uop_reg        <= U_ER2;
            out_valid_reg  <= 1'b0;
            drive_rate_reg <= CFG_W'(3932);
            detuning_reg   <= CFG_W'(655);
            decay_rate_reg <= CFG_W'(1311);
            time_step_reg  <= CFG_W'(6554);
            amp_reg[K_GRE] <= AMP_ONE;
            amp_reg[K_GIM] <= '0;
            amp_reg[K_ERE] <= '0;
            amp_reg[K_EIM] <= '0;
            k_reg          <= '0;
            jumped_reg     <= 1'b0;
        end
        else
        begin
            // A result taken while the next one is ready is replaced in the final state.
            if (out_valid_reg && out_ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_DRIVE_RATE: drive_rate_reg <= cfg_data;
                    REG_DETUNING:   detuning_reg   <= cfg_data;
                    REG_DECAY_RATE: decay_rate_reg <= cfg_data;
                    REG_TIME_STEP:  time_step_reg  <= cfg_data;
                    default:        drive_rate_reg <= drive_rate_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MAC;
                        ph_reg    <= PH_MUL;
                        eps_reg   <= in_data.random_fraction;
                        if (in_data.operation == OP_RESTART)
                        begin
                            amp_reg[K_GRE] <= AMP_ONE;
                            amp_reg[K_GIM] <= '0;
                            amp_reg[K_ERE] <= '0;
                            amp_reg[K_EIM] <= '0;
                            jumped_reg     <= 1'b1;
                            uop_reg        <= U_PG0;
                        end
                        else
                        begin
                            jumped_reg <= 1'b0;
                            uop_reg    <= U_ER2;
                        end
                    end
                end

                S_MAC:
                begin
                    unique case (ph_reg)
                        PH_MUL:
                        begin
                            ph_reg <= PH_ACC;
                        end
                        PH_ACC:
                        begin
                            if (has_store)
                            begin
                                ph_reg <= PH_ST;
                            end
                            else
                            begin
                                ph_reg  <= PH_MUL;
                                uop_reg <= uop_t'(uop_reg + 5'd1);
                            end
                        end
                        default:
                        begin
                            ph_reg <= PH_MUL;
                            if (uop_reg != U_DPHI)
                            begin
                                uop_reg <= uop_t'(uop_reg + 5'd1);
                            end
                            priority case (uop_reg)
                                U_EI2:  pop20_reg <= acc[63:40];
                                U_DTG:  dtg_reg   <= acc[39:0];
                                U_DPHI:
                                begin
                                    // A fraction below the jump probability collapses
                                    // the atom to the ground state.
                                    if (!propagate)
                                    begin
                                        amp_reg[K_GRE] <= AMP_ONE;
                                        amp_reg[K_GIM] <= '0;
                                        amp_reg[K_ERE] <= '0;
                                        amp_reg[K_EIM] <= '0;
                                        jumped_reg     <= 1'b1;
                                        uop_reg        <= U_PG0;
                                    end
                                    else
                                    begin
                                        uop_reg <= U_A;
                                    end
                                end
                                U_A:    a_reg <= a_sum[39:13];
                                U_C:
                                begin
                                    c_reg <= c_next;
                                    d_reg <= d_next;
                                end
                                U_V0B:
                                begin
                                    m_reg[0]   <= acc_abs[M_W-1:0];
                                    neg_reg[0] <= acc[ACC_W-1];
                                end
                                U_V1B:
                                begin
                                    m_reg[1]   <= acc_abs[M_W-1:0];
                                    neg_reg[1] <= acc[ACC_W-1];
                                end
                                U_V2C:
                                begin
                                    m_reg[2]   <= acc_abs[M_W-1:0];
                                    neg_reg[2] <= acc[ACC_W-1];
                                end
                                U_V3C:
                                begin
                                    m_reg[3]   <= acc_abs[M_W-1:0];
                                    neg_reg[3] <= acc[ACC_W-1];
                                    state_reg  <= S_SCALE;
                                end
                                U_S3:   state_reg <= S_SQRT;
                                U_PG1:  pg_reg    <= pop_sat;
                                U_PE1:
                                begin
                                    pe_reg    <= pop_sat;
                                    state_reg <= S_FIN;
                                end
                                default: ;
                            endcase
                        end
                    endcase
                end

                S_SCALE:
                begin
                    // Block scaling: bring the largest magnitude into [2^30, 2^31).
                    priority if (mor == '0)
                    begin
                        amp_reg[K_GRE] <= AMP_ONE;
                        amp_reg[K_GIM] <= '0;
                        amp_reg[K_ERE] <= '0;
                        amp_reg[K_EIM] <= '0;
                        state_reg      <= S_MAC;
                        ph_reg         <= PH_MUL;
                        uop_reg        <= U_PG0;
                    end
                    else if (|mor[M_W-1:AMP_FRAC+9])
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 8;
                        end
                    end
                    else if (|mor[M_W-1:AMP_FRAC+1])
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end
                    else if (mor[M_W-1:AMP_FRAC-8] == '0)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 8;
                        end
                    end
                    else if (!mor[AMP_FRAC])
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_MAC;
                        ph_reg    <= PH_MUL;
                        uop_reg   <= U_S0;
                    end
                end

                S_SQRT:
                begin
                    if (sd_stat.done)
                    begin
                        nrm_reg   <= sd_result;
                        k_reg     <= '0;
                        state_reg <= S_DIVSET;
                    end
                end

                S_DIVSET:
                begin
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (sd_stat.done)
                    begin
                        amp_reg[k_reg] <= neg_reg[k_reg] ? -$signed({1'b0, q_val})
                                                         : $signed({1'b0, q_val});
                        if (k_reg == K_EIM)
                        begin
                            state_reg <= S_MAC;
                            ph_reg    <= PH_MUL;
                            uop_reg   <= U_PG0;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_DIVSET;
                        end
                    end
                end

                default:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.ground_re          <= amp_reg[K_GRE];
                        out_reg.ground_im          <= amp_reg[K_GIM];
                        out_reg.excited_re         <= amp_reg[K_ERE];
                        out_reg.excited_im         <= amp_reg[K_EIM];
                        out_reg.ground_population  <= pg_reg;
                        out_reg.excited_population <= pe_reg;
                        out_reg.jumped             <= jumped_reg;
                        out_valid_reg              <= 1'b1;
                        state_reg                  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sd_stat.busy)
        else $error("shift-subtract unit busy while the core is idle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("core ready again straight after taking a transaction");

    a_pop_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.ground_population <= POP_ONE
                       && out_data.excited_population <= POP_ONE))
        else $error("population above one");
`endif

endmodule

### verif/quantum_jump_two_level_step_core_checker.sv
// Checker for the two-level quantum jump step core: watches both channels and the
// register port, predicts every result and compares it field by field. Depends on qjts_pkg.
module quantum_jump_two_level_step_core_checker
    import qjts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0] drive_rate, detuning, decay_rate, time_step;
    longint           wave[4];   // ground re, ground im, excited re, excited im
    out_item_t        awaited[$];

    assign pending = awaited.size();

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, bit_val;
        r = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > x)
            bit_val >>= 2;
        while (bit_val != 0)
        begin
            if (x >= r + bit_val)
            begin
                x -= r + bit_val;
                r = (r >> 1) + bit_val;
            end
            else
                r >>= 1;
            bit_val >>= 2;
        end
        return r;
    endfunction

    function automatic logic [POP_W-1:0] pop_of(longint re, longint im);
        longint unsigned s, p;
        s = mag(re) * mag(re) + mag(im) * mag(im);
        p = (s >> (2 * AMP_FRAC - 16)) + ((s >> (2 * AMP_FRAC - 17)) & 64'd1);
        return (p > 65536) ? POP_ONE : p[POP_W-1:0];
    endfunction

    task automatic to_ground();
        wave[0] = longint'(1) << AMP_FRAC;
        wave[1] = 0;
        wave[2] = 0;
        wave[3] = 0;
    endtask

    // First-order propagation followed by block scaling and renormalisation.
    task automatic propagate();
        longint unsigned dt, a, b, cm, mx, total, nrm, q;
        longint unsigned m[4];
        longint          dl, c, d, ai;
        longint          v[4];
        dt = time_step;
        a  = (dt * drive_rate + 64'd4096) >> 13;
        b  = (dt * decay_rate + 64'd4096) >> 13;
        dl = longint'($signed(detuning));
        cm = (dt * mag(dl) + 64'd2048) >> 12;
        c  = (dl < 0) ? -longint'(cm) : longint'(cm);
        ai = longint'(a);
        d  = (longint'(1) << COEF_FRAC) - longint'(b);
        v[0] = wave[0] * (longint'(1) << COEF_FRAC) + ai * wave[3];
        v[1] = wave[1] * (longint'(1) << COEF_FRAC) - ai * wave[2];
        v[2] = ai * wave[1] + d * wave[2] - c * wave[3];
        v[3] = -ai * wave[0] + d * wave[3] + c * wave[2];
        mx = 0;
        for (int k = 0; k < 4; k++)
        begin
            m[k] = mag(v[k]);
            if (m[k] > mx)
                mx = m[k];
        end
        if (mx == 0)
        begin
            to_ground();
            return;
        end
        while (mx >= (64'd1 << (AMP_FRAC + 1)))
        begin
            mx >>= 1;
            for (int k = 0; k < 4; k++)
                m[k] >>= 1;
        end
        while (mx < (64'd1 << AMP_FRAC))
        begin
            mx <<= 1;
            for (int k = 0; k < 4; k++)
                m[k] <<= 1;
        end
        total = 0;
        for (int k = 0; k < 4; k++)
            total += m[k] * m[k];
        nrm = floor_sqrt(total);
        for (int k = 0; k < 4; k++)
        begin
            q = ((m[k] << AMP_FRAC) + (nrm >> 1)) / nrm;
            wave[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
        end
    endtask

    task automatic predict_step(in_item_t item);
        out_item_t       res;
        longint unsigned pop20, dp, eps52;
        res.jumped = 1'b0;
        if (item.operation == OP_RESTART)
        begin
            to_ground();
            res.jumped = 1'b1;
        end
        else
        begin
            pop20 = (mag(wave[2]) * mag(wave[2]) + mag(wave[3]) * mag(wave[3]))
                    >> (2 * AMP_FRAC - 20);
            dp    = (64'(decay_rate) * 64'(time_step)) * pop20;
            eps52 = 64'(item.random_fraction) << (52 - RND_W);
            if (eps52 >= dp)
                propagate();
            else
            begin
                to_ground();
                res.jumped = 1'b1;
            end
        end
        res.ground_re          = wave[0][AMP_W-1:0];
        res.ground_im          = wave[1][AMP_W-1:0];
        res.excited_re         = wave[2][AMP_W-1:0];
        res.excited_im         = wave[3][AMP_W-1:0];
        res.ground_population  = pop_of(wave[0], wave[1]);
        res.excited_population = pop_of(wave[2], wave[3]);
        awaited.push_back(res);
    endtask

    task automatic flag_mismatch(string what, longint exp_v, longint act_v);
        if (errors < 10)
            $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what,
                     exp_v, act_v);
        errors++;
    endtask

    task automatic compare_result(out_item_t act);
        out_item_t e;
        if (awaited.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: result transaction with nothing outstanding", $realtime);
            errors++;
            return;
        end
        e = awaited.pop_front();
        if (act.ground_re !== e.ground_re)
            flag_mismatch("ground_re", e.ground_re, act.ground_re);
        if (act.ground_im !== e.ground_im)
            flag_mismatch("ground_im", e.ground_im, act.ground_im);
        if (act.excited_re !== e.excited_re)
            flag_mismatch("excited_re", e.excited_re, act.excited_re);
        if (act.excited_im !== e.excited_im)
            flag_mismatch("excited_im", e.excited_im, act.excited_im);
        if (act.ground_population !== e.ground_population)
            flag_mismatch("ground_population", e.ground_population, act.ground_population);
        if (act.excited_population !== e.excited_population)
            flag_mismatch("excited_population", e.excited_population,
                          act.excited_population);
        if (act.jumped !== e.jumped)
            flag_mismatch("jumped", e.jumped, act.jumped);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_rate = 20'd3932;
            detuning   = 20'd655;
            decay_rate = 20'd1311;
            time_step  = 20'd6554;
            to_ground();
            awaited.delete();
            errors = 0;
        end
        else
        begin
            // The result is compared before the new transaction is predicted.
            if (out_valid && out_ready)
                compare_result(out_data);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DRIVE_RATE: drive_rate = cfg_data;
                    REG_DETUNING:   detuning   = cfg_data;
                    REG_DECAY_RATE: decay_rate = cfg_data;
                    REG_TIME_STEP:  time_step  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_step(in_data);
        end
    end
endmodule

### verif/quantum_jump_two_level_step_core_test.sv
// Top of the testbench for the two-level quantum jump step core: clock, reset, stimulus,
// register phases, watchdog and verdict. Depends on qjts_pkg, the core and its checker.
module quantum_jump_two_level_step_core_test;
    import qjts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    bit                   calm;     // no idling on either side while set
    int                   quiet_cycles;

    quantum_jump_two_level_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    quantum_jump_two_level_step_core_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(logic op, logic [RND_W-1:0] frac);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.operation = op;
        in_data.random_fraction = frac;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic load_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] det,
                             logic [CFG_W-1:0] g, logic [CFG_W-1:0] dt);
        drain();
        write_reg(REG_DRIVE_RATE, w);
        write_reg(REG_DETUNING, det);
        write_reg(REG_DECAY_RATE, g);
        write_reg(REG_TIME_STEP, dt);
    endtask

    // Mostly propagating steps; small fractions provoke jumps, a few restarts.
    task automatic random_run(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            calm = (n >= count / 3) && (n < count / 3 + 30);
            pick = $urandom_range(99);
            if (pick < 8)
                send(OP_RESTART, RND_W'($urandom));
            else if (pick < 30)
                send(OP_STEP, RND_W'($urandom_range(255)));
            else
                send(OP_STEP, RND_W'($urandom));
            if (n == count / 2)
                drain();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_DRIVE_RATE;
        cfg_data     = '0;
        calm         = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset, strongly decaying, all-zero and decay-free settings.
        send(OP_STEP, 16'hFFFF);
        send(OP_STEP, 16'h0000);
        send(OP_RESTART, 16'hFFFF);
        for (int n = 0; n < 6; n++)
            send(OP_STEP, 16'h8000);
        send(OP_STEP, 16'h0001);
        send(OP_RESTART, 16'h0000);
        load_regs(20'hFFFFF, 20'h80000, 20'hFFFFF, 20'hFFFFF);
        for (int n = 0; n < 4; n++)
            send(OP_STEP, 16'hFFFF);
        send(OP_STEP, 16'h0000);
        load_regs(20'h00000, 20'h00000, 20'h00000, 20'h00000);
        send(OP_STEP, 16'h1234);
        send(OP_STEP, 16'h0000);
        load_regs(20'h40000, 20'h7FFFF, 20'h00000, 20'h10000);
        for (int n = 0; n < 5; n++)
            send(OP_STEP, 16'hFFFF);

        load_regs(20'd3932, 20'd655, 20'd1311, 20'd6554);
        random_run(150);
        load_regs(20'hFFFFF, 20'h80000, 20'hFFFFF, 20'hFFFFF);
        random_run(80);
        load_regs(20'h00000, 20'h7FFFF, 20'h00000, 20'h00000);
        random_run(60);
        for (int ph = 0; ph < 5; ph++)
        begin
            load_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(20000)),
                      CFG_W'($urandom_range(40000)));
            random_run(60);
        end
        load_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        random_run(60);

        drain();
        repeat (300) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
